// File: rtl/core/hierarchical_timebin_assigner_core_assert.svh
// assertion macros shared by the timebin assigner modules
`ifndef HIERARCHICAL_TIMEBIN_ASSIGNER_CORE_ASSERT_SVH
`define HIERARCHICAL_TIMEBIN_ASSIGNER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HTBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("htba assertion failed");

// next-cycle implication, checked outside reset
`define HTBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("htba assertion failed");

`endif

// File: rtl/core/htba_pkg.sv
// types, widths and the step-to-bin function of the timebin assigner
package htba_pkg;

	localparam int STEP_W = 30;
	localparam int OLD_W  = 5;
	localparam int BIN_W  = 6;
	localparam int CNT_W  = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic signed [BIN_W-1:0] bin_t;

	typedef struct packed {
		logic load;
		logic dec;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic lower;
	} dp_stat_t;

	// floor of log2, with step 0 giving bin 0 and step 1 giving bin -1
	function automatic bin_t step_bin(input logic [STEP_W-1:0] step);
		bin_t r;
		r = '0;
		if (step == STEP_W'(1))
			r = -BIN_W'(1);
		for (int i = 1; i < STEP_W; i++) begin
			if (step[i])
				r = bin_t'(i);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/htba_dp.sv
// datapath: time register, bin register with decrement, running totals, output word
`include "hierarchical_timebin_assigner_core_assert.svh"

module htba_dp #(
	parameter int TIME_BINS = 29
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  htba_pkg::ctrl_cmd_t               cmd,
	output htba_pkg::dp_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [htba_pkg::STEP_W-1:0]       cfg_wdata,
	input  logic [htba_pkg::STEP_W-1:0]       requested_step,
	input  logic [htba_pkg::OLD_W-1:0]        old_bin,
	input  logic                              is_last,
	output logic signed [htba_pkg::BIN_W-1:0] new_bin,
	output logic                              bad_step,
	output logic signed [htba_pkg::BIN_W-1:0] min_bin,
	output logic [htba_pkg::CNT_W-1:0]        bad_count,
	output logic                              last_out
);

	localparam htba_pkg::bin_t MIN_RESET = htba_pkg::bin_t'(TIME_BINS);

	logic [htba_pkg::STEP_W-1:0] time_q;
	htba_pkg::bin_t              bin_q;
	logic [htba_pkg::OLD_W-1:0]  old_q;
	logic                        bad_q;
	logic                        last_q;
	htba_pkg::bin_t              run_min_q;
	logic [htba_pkg::CNT_W-1:0]  run_cnt_q;

	htba_pkg::bin_t              min_nxt;
	logic [htba_pkg::CNT_W-1:0]  cnt_nxt;
	logic [htba_pkg::STEP_W-1:0] low_mask;
	logic                        gt_old;
	logic                        inactive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (cfg_we) begin
			time_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= htba_pkg::step_bin(requested_step);
			bad_q  <= (requested_step[htba_pkg::STEP_W-1:1] == '0);
			old_q  <= old_bin;
			last_q <= is_last;
		end else if (cmd.dec) begin
			bin_q <= bin_q - htba_pkg::bin_t'(1);
		end
	end

	// bin is active when the time is a multiple of 2^bin; only checked while bin > 1
	assign low_mask = (htba_pkg::STEP_W'(1) << bin_q[htba_pkg::OLD_W-1:0]) - htba_pkg::STEP_W'(1);
	assign inactive = (time_q != '0) && ((time_q & low_mask) != '0);
	assign gt_old   = bin_q > $signed({1'b0, old_q});

	assign stat.lower = gt_old && (bin_q > htba_pkg::bin_t'(1)) && inactive;

	assign min_nxt = (bin_q < run_min_q) ? bin_q : run_min_q;
	assign cnt_nxt = (bad_q && run_cnt_q != htba_pkg::CNT_MAX) ?
		run_cnt_q + htba_pkg::CNT_W'(1) : run_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= MIN_RESET;
			run_cnt_q <= '0;
		end else if (cmd.emit) begin
			if (last_q) begin
				run_min_q <= MIN_RESET;
				run_cnt_q <= '0;
			end else begin
				run_min_q <= min_nxt;
				run_cnt_q <= cnt_nxt;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			new_bin   <= bin_q;
			bad_step  <= bad_q;
			min_bin   <= min_nxt;
			bad_count <= cnt_nxt;
			last_out  <= last_q;
		end
	end

	`HTBA_ASSERT_NEXT(a_dec_floor, clk, arst_n, cmd.dec, bin_q >= htba_pkg::bin_t'(1))
	`HTBA_ASSERT_NOW(a_dec_needs_lower, clk, arst_n, cmd.dec, stat.lower)

endmodule

// File: rtl/core/htba_ctrl.sv
// controller: accept, bin-lowering loop, and output word hand-off
`include "hierarchical_timebin_assigner_core_assert.svh"

module htba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  htba_pkg::dp_stat_t  stat,
	output htba_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOWER = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_LOWER;
				end
			end
			ST_LOWER: begin
				// one bin down per cycle until the bin is active or bounded
				if (stat.lower)
					cmd.dec = 1'b1;
				else
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`HTBA_ASSERT_NOW(a_emit_slot_free, clk, arst_n, cmd.emit, !out_valid_q || out_ready)
	`HTBA_ASSERT_NEXT(a_accept_to_lower, clk, arst_n, in_valid && in_ready, state_q == ST_LOWER)
	`HTBA_ASSERT_NEXT(a_emit_sets_valid, clk, arst_n, cmd.emit, out_valid_q && state_q == ST_IDLE)

endmodule

// File: rtl/core/hierarchical_timebin_assigner_core.sv
// top level of the timebin assigner: controller plus datapath
//
//  channel  handshake              payload
//  in       in_valid / in_ready    requested_step, old_bin, is_last
//  out      out_valid / out_ready  new_bin, bad_step, min_bin, bad_count, last_out
//  cfg      cfg_we                 cfg_wdata (current_time)
//
// each word goes through accept, the lowering loop and the output hand-off
// the loop lowers the bin by 0 to 28 bins, stepping the bin register down one bin per cycle
// the output register frees the input side: the next word is taken while a result waits
// a stalled output holds the finished word in the last state until the register frees
// arst_n clears the state, the running totals and current_time

module hierarchical_timebin_assigner_core #(
	parameter int TIME_BINS = 29
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [htba_pkg::STEP_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [htba_pkg::STEP_W-1:0]       requested_step,
	input  logic [htba_pkg::OLD_W-1:0]        old_bin,
	input  logic                              is_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [htba_pkg::BIN_W-1:0] new_bin,
	output logic                              bad_step,
	output logic signed [htba_pkg::BIN_W-1:0] min_bin,
	output logic [htba_pkg::CNT_W-1:0]        bad_count,
	output logic                              last_out
);

	htba_pkg::ctrl_cmd_t cmd;
	htba_pkg::dp_stat_t  stat;

	htba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	htba_dp #(
		.TIME_BINS (TIME_BINS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.requested_step (requested_step),
		.old_bin        (old_bin),
		.is_last        (is_last),
		.new_bin        (new_bin),
		.bad_step       (bad_step),
		.min_bin        (min_bin),
		.bad_count      (bad_count),
		.last_out       (last_out)
	);

endmodule

// File: tb/htba_result_checker.sv
// checker for the timebin assigner: predicts each result word and compares it with the block
module htba_result_checker
	import htba_pkg::*;
#(
	parameter int TIME_BINS = 29
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [STEP_W-1:0]       cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [STEP_W-1:0]       requested_step,
	input  logic [OLD_W-1:0]        old_bin,
	input  logic                    is_last,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  bin_t                    new_bin,
	input  logic                    bad_step,
	input  bin_t                    min_bin,
	input  logic [CNT_W-1:0]        bad_count,
	input  logic                    last_out,
	output int                      pending,
	output int                      fails
);

	typedef struct packed {
		bin_t              new_bin;
		logic              bad_step;
		bin_t              min_bin;
		logic [CNT_W-1:0]  bad_count;
		logic              last_out;
	} bin_word_t;

	bin_word_t         bin_words_due[$];
	logic [STEP_W-1:0] sim_time;
	int                pass_min_bin;
	int                pass_bad_count;

	function automatic logic bin_is_active(input int b, input logic [STEP_W-1:0] t);
		if (b <= 0 || t == '0)
			return 1'b1;
		return (t & ((STEP_W'(1) << b) - STEP_W'(1))) == '0;
	endfunction

	// floor of log2 of the step, then stepped down while the bin is inactive, above the old bin and above 1
	function automatic int assigned_bin(input logic [STEP_W-1:0] step,
			input logic [OLD_W-1:0] ob, input logic [STEP_W-1:0] t);
		int               b;
		int               prev;
		logic [STEP_W-1:0] s;
		prev = int'(ob);
		if (step == '0) begin
			b = 0;
		end else if (step == STEP_W'(1)) begin
			b = -1;
		end else begin
			b = -1;
			s = step;
			while (s != '0) begin
				b++;
				s = s >> 1;
			end
		end
		if (b > prev) begin
			while (!bin_is_active(b, t) && b > prev && b > 1)
				b--;
		end
		return b;
	endfunction

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$error("%s: expected %0d, actual %0d", name, expv, actv);
			fails++;
		end
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		bin_word_t want;
		int        b;
		logic      bad;
		if (!arst_n) begin
			bin_words_due.delete();
			sim_time = '0;
			pass_min_bin = TIME_BINS;
			pass_bad_count = 0;
		end else begin
			// results first: a word taken at this edge cannot have its result out yet
			if (out_valid && out_ready) begin
				if (bin_words_due.size() == 0) begin
					$error("result word with no word pending");
					fails++;
				end else begin
					want = bin_words_due.pop_front();
					check_field("new_bin", int'(want.new_bin), int'(new_bin));
					check_field("bad_step", int'(want.bad_step), int'(bad_step));
					check_field("min_bin", int'(want.min_bin), int'(min_bin));
					check_field("bad_count", int'(want.bad_count), int'(bad_count));
					check_field("last_out", int'(want.last_out), int'(last_out));
				end
			end
			if (in_valid && in_ready) begin
				b = assigned_bin(requested_step, old_bin, sim_time);
				// lowering never takes a bin below 1, so badness follows the raw step
				bad = requested_step < STEP_W'(2);
				if (bad && pass_bad_count < int'(CNT_MAX))
					pass_bad_count++;
				if (b < pass_min_bin)
					pass_min_bin = b;
				want.new_bin = bin_t'(b);
				want.bad_step = bad;
				want.min_bin = bin_t'(pass_min_bin);
				want.bad_count = CNT_W'(pass_bad_count);
				want.last_out = is_last;
				bin_words_due.push_back(want);
				if (is_last) begin
					pass_min_bin = TIME_BINS;
					pass_bad_count = 0;
				end
			end
			if (cfg_we)
				sim_time = cfg_wdata;
		end
		pending = bin_words_due.size();
	end

endmodule

// File: tb/tb_hierarchical_timebin_assigner_core.sv
// testbench top for the timebin assigner: clock, reset, stimulus and verdict
module tb_hierarchical_timebin_assigner_core;
	import htba_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [STEP_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [STEP_W-1:0] requested_step;
	logic [OLD_W-1:0]  old_bin;
	logic              is_last;
	logic              out_valid;
	logic              out_ready;
	bin_t              new_bin;
	logic              bad_step;
	bin_t              min_bin;
	logic [CNT_W-1:0]  bad_count;
	logic              last_out;
	int                pending;
	int                fails;

	logic no_idle;
	logic hold_burst;
	int   words_sent;
	int   passes;
	int   settings;

	hierarchical_timebin_assigner_core #(
		.TIME_BINS(29)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.requested_step(requested_step),
		.old_bin(old_bin),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.new_bin(new_bin),
		.bad_step(bad_step),
		.min_bin(min_bin),
		.bad_count(bad_count),
		.last_out(last_out)
	);

	htba_result_checker #(
		.TIME_BINS(29)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.requested_step(requested_step),
		.old_bin(old_bin),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.new_bin(new_bin),
		.bad_step(bad_step),
		.min_bin(min_bin),
		.bad_count(bad_count),
		.last_out(last_out),
		.pending(pending),
		.fails(fails)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [STEP_W-1:0] rand_step();
		int e;
		case ($urandom_range(0, 19))
			0: return '0;
			1: return STEP_W'(1);
			default: begin
				e = $urandom_range(1, STEP_W - 1);
				return (STEP_W'(1) << e) |
					(STEP_W'($urandom()) & ((STEP_W'(1) << e) - STEP_W'(1)));
			end
		endcase
	endfunction

	// low old bins make the lowering loop run more often
	function automatic logic [OLD_W-1:0] rand_old();
		if ($urandom_range(0, 1) == 0)
			return OLD_W'($urandom_range(0, 5));
		return OLD_W'($urandom_range(0, 31));
	endfunction

	function automatic logic [STEP_W-1:0] rand_time();
		case ($urandom_range(0, 3))
			0: return STEP_W'($urandom());
			1: return STEP_W'(($urandom() | 1) << $urandom_range(0, STEP_W - 1));
			2: return STEP_W'($urandom_range(1, 64));
			default: return STEP_W'(1) << $urandom_range(0, STEP_W - 1);
		endcase
	endfunction

	// receiver: random stalls, plus one long hold when hold_burst rises
	initial begin : sink
		int   gap_left;
		int   hold_left;
		logic burst_seen;
		gap_left = 0;
		hold_left = 0;
		burst_seen = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_burst && !burst_seen)
				hold_left = 300;
			burst_seen = hold_burst;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				gap_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [STEP_W-1:0] step, input logic [OLD_W-1:0] ob,
			input logic lst);
		int g;
		@(negedge clk);
		in_valid <= 1'b1;
		requested_step <= step;
		old_bin <= ob;
		is_last <= lst;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (lst)
			passes++;
		if (!no_idle && $urandom_range(0, 2) == 0) begin
			g = idle_len();
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_time(input logic [STEP_W-1:0] t);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic send_passes(input int count);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			len = $urandom_range(1, 30);
			if (len > count - n)
				len = count - n;
			for (int j = 0; j < len; j++) begin
				// an occasional early end of pass
				send_word(rand_step(), rand_old(), j == len - 1 || $urandom_range(0, 40) == 0);
				n++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		requested_step = '0;
		old_bin = '0;
		is_last = 1'b0;
		no_idle = 1'b0;
		hold_burst = 1'b0;
		words_sent = 0;
		passes = 0;
		settings = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// time 0 from reset: every bin active, no lowering
		send_word('0, OLD_W'(0), 1'b0);
		send_word(STEP_W'(1), OLD_W'(0), 1'b0);
		send_word(STEP_W'(2), OLD_W'(0), 1'b0);
		send_word(STEP_W'(3), OLD_W'(7), 1'b0);
		send_word(STEP_W'(30'h2000_0000), OLD_W'(0), 1'b0);
		send_word(STEP_W'(30'h3FFF_FFFF), OLD_W'(31), 1'b0);
		send_word(STEP_W'(4), OLD_W'(30), 1'b1);
		// odd time: lowering runs down to bin 1 or the old bin
		set_time(STEP_W'(1));
		send_word(STEP_W'(30'h2000_0000), OLD_W'(0), 1'b0);
		send_word(STEP_W'(30'h2000_0000), OLD_W'(5), 1'b0);
		send_word(STEP_W'(30'h0010_0000), OLD_W'(31), 1'b0);
		send_word(STEP_W'(1), OLD_W'(0), 1'b1);
		set_time(STEP_W'(30'h2000_0000));
		send_word(STEP_W'(30'h2000_0000), OLD_W'(0), 1'b0);
		send_word(STEP_W'(30'h0000_FFFF), OLD_W'(2), 1'b1);
		set_time(STEP_W'(30'h3FFF_FFFF));
		send_word(STEP_W'(30'h3FFF_FFFF), OLD_W'(0), 1'b0);
		send_word(STEP_W'(30'h1555_5555), OLD_W'(12), 1'b0);
		send_word('0, OLD_W'(31), 1'b1);
		// eight trailing zeros: lowering stops at bin 8, or at the old bin if that is higher
		set_time(STEP_W'(30'h100));
		send_word(STEP_W'(30'h2000_0000), OLD_W'(3), 1'b0);
		send_word(STEP_W'(30'h2000_0000), OLD_W'(10), 1'b0);
		send_word(STEP_W'(30'h40), OLD_W'(0), 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_time('0);
				1: set_time(STEP_W'(30'h3FFF_FFFF));
				2: set_time(STEP_W'(30'h2000_0000));
				default: set_time(rand_time());
			endcase
			if (ph == 3) begin
				// long output hold while words keep coming, so the input stalls
				no_idle = 1'b1;
				hold_burst = 1'b1;
				send_passes(40);
				hold_burst = 1'b0;
				no_idle = 1'b0;
				send_passes(170);
			end else if (ph == 5) begin
				send_passes(100);
				wait_drained();
				send_passes(110);
			end else begin
				no_idle = ph == 6;
				send_passes(210);
				no_idle = 1'b0;
			end
		end

		set_time(rand_time());
		send_passes(20);

		wait_drained();
		repeat (40) @(negedge clk);
		$display("covered %0d words in %0d passes over %0d time settings",
			words_sent, passes, settings);
		$display("with random gaps on both sides, a long output hold and early pass ends");
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
